/* hdl/irt_pkg.sv */
// ----------------------------------------------------------------------------
// irt_pkg
// Types and constants shared by the interval range table blocks.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 8;

    localparam logic       CMD_ASSIGN = 1'b0;
    localparam logic       CMD_LOOKUP = 1'b1;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] key_begin;
        logic signed [KEY_W-1:0] key_end;
        logic [VAL_W-1:0]        new_value;
    } irt_in_t;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [1:0]       status;
    } irt_out_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } irt_cmp_t;

endpackage

/* hdl/irt_key_cmp.sv */
// ----------------------------------------------------------------------------
// irt_key_cmp
// Shared signed key comparator used by the sequencer for every key test.
// ----------------------------------------------------------------------------
module irt_key_cmp
    import irt_pkg::*;
(
    input  logic signed [KEY_W-1:0] a,
    input  logic signed [KEY_W-1:0] b,
    output irt_cmp_t                res
);

    assign res.lt = (a < b);
    assign res.eq = (a == b);

endmodule

/* hdl/irt_table_mem.sv */
// ----------------------------------------------------------------------------
// irt_table_mem
// Boundary key/value storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module irt_table_mem
    import irt_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic signed [KEY_W-1:0] wkey,
    input  logic [VAL_W-1:0]        wval,
    input  logic [AW-1:0]           raddr,
    output logic signed [KEY_W-1:0] rkey,
    output logic [VAL_W-1:0]        rval
);

    logic signed [KEY_W-1:0] key_mem [DEPTH];
    logic [VAL_W-1:0]        val_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wkey;
            val_mem[waddr] <= wval;
        end
        rkey <= key_mem[raddr];
        rval <= val_mem[raddr];
    end

endmodule

/* hdl/interval_range_table_unit.sv */
// ----------------------------------------------------------------------------
// interval_range_table_unit
// Sorted boundary table with range assign and point lookup.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one command per transfer: assign new_value over
//   [key_begin, key_end) or look up key_begin. Each transfer yields exactly
//   one result transfer on out_valid/out_ready (read_value, status).
//   cfg_we/cfg_wdata write the default value; write only while idle.
// Sequencing:
//   A lookup scans every entry in the table (one shared comparator, one
//   memory read per entry). An assign also scans the entries, then shifts
//   the tail one entry at a time when its position changes. An empty
//   range is answered without a scan. in_ready is high only when the
//   sequencer is idle.
// Reset:
//   The table empties (entry count zero), default value 0, no result pending.
// Stall:
//   A finished result waits in the output register; the next command is
//   accepted meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module interval_range_table_unit
    import irt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  irt_in_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output irt_out_t         out_data,
    input  logic             cfg_we,
    input  logic [VAL_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW:0] DEPTH_C = (CW+1)'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_B, S_SCAN_E, S_PLAN,
        S_MV_NX, S_MV_RD, S_MV_WR, S_WR_B, S_WR_E, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    irt_in_t           item_reg, item_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     off_reg, off_next;
    logic [CW:0]       total_reg, total_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [VAL_W-1:0]  left_reg, left_next;
    logic [VAL_W-1:0]  right_reg, right_next;
    logic              pb_reg, pb_next;
    logic              pe_reg, pe_next;
    logic              up_reg, up_next;
    irt_out_t          res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    irt_out_t          out_reg, out_next;
    logic [VAL_W-1:0]  default_reg;

    logic signed [KEY_W-1:0] cmp_a, cmp_b;
    irt_cmp_t                cmp;
    logic signed [KEY_W-1:0] rkey;
    logic [VAL_W-1:0]        rval;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic signed [KEY_W-1:0] wkey;
    logic [VAL_W-1:0]        wval;

    logic                    pb_c, pe_c;
    logic [CW:0]             tot_c, newpos_c, dst_c;

    irt_key_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp)
    );

    irt_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wkey  (wkey),
        .wval  (wval),
        .raddr (addr_reg),
        .rkey  (rkey),
        .rval  (rval)
    );

    always_comb
    begin
        cmp_a = rkey;
        cmp_b = item_reg.key_begin;
        if (state_reg == S_CHECK)
        begin
            cmp_a = item_reg.key_begin;
            cmp_b = item_reg.key_end;
        end
        else if (state_reg == S_SCAN_E)
        begin
            cmp_b = item_reg.key_end;
        end
    end

    assign pb_c     = (item_reg.new_value != left_reg);
    assign pe_c     = (right_reg != item_reg.new_value);
    assign tot_c    = {1'b0, count_reg} - {1'b0, hi_reg} + {1'b0, lo_reg}
                      + (CW+1)'(pb_c) + (CW+1)'(pe_c);
    assign newpos_c = {1'b0, lo_reg} + (CW+1)'(pb_c) + (CW+1)'(pe_c);
    assign dst_c    = up_reg ? ((CW+1)'(addr_reg) - {1'b0, off_reg})
                             : ((CW+1)'(addr_reg) + {1'b0, off_reg});

    // memory write port
    always_comb
    begin
        we    = 1'b0;
        waddr = dst_c[AW-1:0];
        wkey  = rkey;
        wval  = rval;
        unique case (state_reg)
            S_MV_WR:
            begin
                we = 1'b1;
            end
            S_WR_B:
            begin
                we    = pb_reg;
                waddr = lo_reg[AW-1:0];
                wkey  = item_reg.key_begin;
                wval  = item_reg.new_value;
            end
            S_WR_E:
            begin
                we    = pe_reg;
                waddr = lo_reg[AW-1:0] + AW'(pb_reg);
                wkey  = item_reg.key_end;
                wval  = right_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        off_next       = off_reg;
        total_next     = total_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        pb_next        = pb_reg;
        pe_next        = pe_reg;
        up_next        = up_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                i_next     = '0;
                lo_next    = '0;
                hi_next    = '0;
                left_next  = default_reg;
                right_next = default_reg;
                addr_next  = '0;
                if (item_reg.command == CMD_ASSIGN && !cmp.lt)
                begin
                    res_next   = '{read_value: '0, status: STAT_EMPTY};
                    state_next = S_DONE;
                end
                else if (count_reg == '0)
                begin
                    state_next = S_PLAN;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_B;
            end
            S_SCAN_B, S_SCAN_E:
            begin
                if (state_reg == S_SCAN_E)
                begin
                    if (cmp.lt || cmp.eq)
                    begin
                        hi_next    = i_reg + 1'b1;
                        right_next = rval;
                    end
                end
                else if (cmp.lt || (cmp.eq && item_reg.command == CMD_LOOKUP))
                begin
                    lo_next   = i_reg + 1'b1;
                    left_next = rval;
                end
                if (state_reg == S_SCAN_B && item_reg.command == CMD_ASSIGN)
                begin
                    state_next = S_SCAN_E;
                end
                else if (i_reg + 1'b1 == count_reg)
                begin
                    state_next = S_PLAN;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    addr_next  = i_next[AW-1:0];
                    state_next = S_SCAN_RD;
                end
            end
            S_PLAN:
            begin
                pb_next    = pb_c;
                pe_next    = pe_c;
                total_next = tot_c;
                if (item_reg.command == CMD_LOOKUP)
                begin
                    res_next   = '{read_value: left_reg, status: STAT_DONE};
                    state_next = S_DONE;
                end
                else if (tot_c > DEPTH_C)
                begin
                    res_next   = '{read_value: '0, status: STAT_FULL};
                    state_next = S_DONE;
                end
                else
                begin
                    // tail moves toward higher slots: walk it from the top down
                    if (newpos_c > {1'b0, hi_reg})
                    begin
                        up_next  = 1'b0;
                        off_next = CW'(newpos_c - {1'b0, hi_reg});
                        i_next   = count_reg;
                    end
                    else
                    begin
                        up_next  = 1'b1;
                        off_next = CW'({1'b0, hi_reg} - newpos_c);
                        i_next   = hi_reg;
                    end
                    state_next = (newpos_c == {1'b0, hi_reg}) ? S_WR_B : S_MV_NX;
                end
            end
            S_MV_NX:
            begin
                if (!up_reg && i_reg > hi_reg)
                begin
                    i_next     = i_reg - 1'b1;
                    addr_next  = i_next[AW-1:0];
                    state_next = S_MV_RD;
                end
                else if (up_reg && i_reg < count_reg)
                begin
                    addr_next  = i_reg[AW-1:0];
                    i_next     = i_reg + 1'b1;
                    state_next = S_MV_RD;
                end
                else
                begin
                    state_next = S_WR_B;
                end
            end
            S_MV_RD:
            begin
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                state_next = S_MV_NX;
            end
            S_WR_B:
            begin
                state_next = S_WR_E;
            end
            S_WR_E:
            begin
                count_next = total_reg[CW-1:0];
                res_next   = '{read_value: '0, status: STAT_DONE};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            count_reg     <= '0;
            i_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            off_reg       <= '0;
            total_reg     <= '0;
            addr_reg      <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            pb_reg        <= 1'b0;
            pe_reg        <= 1'b0;
            up_reg        <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            default_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            off_reg       <= off_next;
            total_reg     <= total_next;
            addr_reg      <= addr_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            pb_reg        <= pb_next;
            pe_reg        <= pe_next;
            up_reg        <= up_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            if (cfg_we)
            begin
                default_reg <= cfg_wdata;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= STAT_FULL)
        else $error("illegal status code");

    a_assign_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != STAT_DONE) |-> out_data.read_value == '0)
        else $error("rejected assign carries a value");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer took a second command at once");

    a_count_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WR_E) |=> $stable(count_reg))
        else $error("entry count changed outside commit");

endmodule
